/* rtl/core/mur64b_pkg.sv */
// ----------------------------------------------------------------------------
// mur64b_pkg
// Constants and helpers shared by the 64-bit MurmurHash2 (64B) key hash core.
// ----------------------------------------------------------------------------
package mur64b_pkg;

    // Mixing multiplier and the shift amounts of the word and final mixes.
    localparam logic [31:0] MUR_M    = 32'h5bd1e995;
    localparam int unsigned MUR_R    = 24;
    localparam int unsigned FIN_SH_A = 18;
    localparam int unsigned FIN_SH_B = 22;
    localparam int unsigned FIN_SH_C = 17;
    localparam int unsigned FIN_SH_D = 19;

    // Configuration register indexes.
    localparam int unsigned CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] REG_HASH_SEED  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_KEY_LENGTH = 2'd1;

    // Register widths and reset values.
    localparam int unsigned SEED_W       = 64;
    localparam int unsigned KEY_LEN_W    = 7;
    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 7'd16;

    // Low 32 bits of a product with the mixing multiplier.
    function automatic logic [31:0] mul_m(input logic [31:0] x);
        logic [63:0] prod;
        prod = {32'd0, x} * {32'd0, MUR_M};
        return prod[31:0];
    endfunction

endpackage

/* rtl/core/murmur64b_key_hash_core.sv */
// ----------------------------------------------------------------------------
// murmur64b_key_hash_core
// Streaming 64-bit MurmurHash2 (64B variant) of fixed-length keys, built
// around one shared 32-bit multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
// Key words enter on the s_ channel, one little-endian 32-bit word per
// transfer, key_length bytes per key (0 acts as 1, values above
// MAX_KEY_BYTES saturate). When the last word of a key has been taken the
// 64-bit hash leaves on the m_ channel, h1 in the upper half.
// Each transfer runs through the shared multiplier: a full word that does
// not end the key takes accept plus three multiplies (K1 to K3), a tail
// word takes accept plus the TAIL multiply. A key-ending word then runs
// the final cross-mix in states F1 to F4 before the hash is registered.
// s_tready is high only while the sequencer is idle.
// The hash sits in an output register; the next key is taken while it
// waits. If a second hash is ready before the first is taken, the
// sequencer holds in its last finalize step until the output is free.
// A seed or key-length write reloads the key state and drops any key in
// progress; the user makes writes only while the core is idle (not enforced).
// Reset (aresetn low, synchronous) sets the seed to 0, the key length to
// 16 and empties the output register.
// ----------------------------------------------------------------------------
module murmur64b_key_hash_core
    import mur64b_pkg::*;
#(
    parameter int unsigned MAX_KEY_BYTES = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port.
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [SEED_W-1:0]     cfg_wdata,
    // Key word input.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,   // [31:0] data_word
    // Hash output.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [63:0]           m_tdata    // [63:0] hash_value
);

    localparam int unsigned CNT_W = $clog2(MAX_KEY_BYTES + 1);
    localparam int unsigned CMP_W = (CNT_W > KEY_LEN_W) ? CNT_W : KEY_LEN_W;

    // Sequencer states.
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_K1   = 4'd1;
    localparam logic [3:0] ST_K2   = 4'd2;
    localparam logic [3:0] ST_K3   = 4'd3;
    localparam logic [3:0] ST_TAIL = 4'd4;
    localparam logic [3:0] ST_F1   = 4'd5;
    localparam logic [3:0] ST_F2   = 4'd6;
    localparam logic [3:0] ST_F3   = 4'd7;
    localparam logic [3:0] ST_F4   = 4'd8;

    logic [3:0]           state_reg, state_next;
    logic [SEED_W-1:0]    seed_reg, seed_next;
    logic [KEY_LEN_W-1:0] key_len_reg, key_len_next;
    logic [31:0]          mix_high_reg, mix_high_next;
    logic [31:0]          mix_low_reg, mix_low_next;
    logic [CNT_W-1:0]     bytes_left_reg, bytes_left_next;
    logic                 parity_reg, parity_next;
    logic [31:0]          word_reg, word_next;
    logic [31:0]          acc_reg, acc_next;
    logic                 out_valid_reg, out_valid_next;
    logic [63:0]          out_data_reg, out_data_next;

    logic [CMP_W-1:0]     len_ext;
    logic [CNT_W-1:0]     start_len;
    logic [31:0]          start_high;
    logic [31:0]          mul_in;
    logic [31:0]          mul_out;
    logic [31:0]          tail_mask;
    logic                 cfg_hit;
    logic                 in_xfer;
    logic                 out_free;

    // Configuration register updates.
    always_comb begin
        seed_next    = seed_reg;
        key_len_next = key_len_reg;
        cfg_hit      = 1'b0;
        if (cfg_we) begin
            unique case (cfg_addr)
                REG_HASH_SEED: begin
                    seed_next = cfg_wdata;
                    cfg_hit   = 1'b1;
                end
                REG_KEY_LENGTH: begin
                    key_len_next = cfg_wdata[KEY_LEN_W-1:0];
                    cfg_hit      = 1'b1;
                end
                default: begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    // Effective key length and the start values of a new key.
    always_comb begin
        len_ext = CMP_W'(key_len_next);
        if (len_ext == '0) begin
            len_ext = CMP_W'(1);
        end
        if (len_ext > CMP_W'(MAX_KEY_BYTES)) begin
            len_ext = CMP_W'(MAX_KEY_BYTES);
        end
        start_len  = len_ext[CNT_W-1:0];
        start_high = seed_next[31:0] ^ 32'(start_len);
    end

    // Byte mask of a tail word holding one to three key bytes.
    always_comb begin
        case (bytes_left_reg[1:0])
            2'd1:    tail_mask = 32'h0000_00ff;
            2'd2:    tail_mask = 32'h0000_ffff;
            2'd3:    tail_mask = 32'h00ff_ffff;
            default: tail_mask = 32'h0000_0000;
        endcase
    end

    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // Operand select for the shared multiplier.
    always_comb begin
        case (state_reg)
            ST_K1:   mul_in = word_reg;
            ST_K2:   mul_in = acc_reg ^ (acc_reg >> MUR_R);
            ST_K3:   mul_in = parity_reg ? mix_low_reg : mix_high_reg;
            ST_TAIL: mul_in = mix_low_reg;
            ST_F1:   mul_in = mix_high_reg ^ (mix_low_reg >> FIN_SH_A);
            ST_F2:   mul_in = mix_low_reg ^ (mix_high_reg >> FIN_SH_B);
            ST_F3:   mul_in = mix_high_reg ^ (mix_low_reg >> FIN_SH_C);
            ST_F4:   mul_in = mix_low_reg ^ (mix_high_reg >> FIN_SH_D);
            default: mul_in = word_reg;
        endcase
    end

    assign mul_out = mul_m(mul_in);

    // Sequencer and datapath next state.
    always_comb begin
        state_next      = state_reg;
        mix_high_next   = mix_high_reg;
        mix_low_next    = mix_low_reg;
        bytes_left_next = bytes_left_reg;
        parity_next     = parity_reg;
        word_next       = word_reg;
        acc_next        = acc_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    word_next = s_tdata;
                    if (bytes_left_reg >= CNT_W'(4)) begin
                        state_next = ST_K1;
                    end else begin
                        mix_low_next = mix_low_reg ^ (s_tdata & tail_mask);
                        state_next   = ST_TAIL;
                    end
                end
            end
            ST_K1: begin
                acc_next   = mul_out;
                state_next = ST_K2;
            end
            ST_K2: begin
                acc_next   = mul_out;
                state_next = ST_K3;
            end
            ST_K3: begin
                if (parity_reg) begin
                    mix_low_next = mul_out ^ acc_reg;
                end else begin
                    mix_high_next = mul_out ^ acc_reg;
                end
                parity_next     = !parity_reg;
                bytes_left_next = bytes_left_reg - CNT_W'(4);
                state_next      = (bytes_left_reg == CNT_W'(4)) ? ST_F1 : ST_IDLE;
            end
            ST_TAIL: begin
                mix_low_next    = mul_out;
                bytes_left_next = '0;
                state_next      = ST_F1;
            end
            ST_F1: begin
                mix_high_next = mul_out;
                state_next    = ST_F2;
            end
            ST_F2: begin
                mix_low_next = mul_out;
                state_next   = ST_F3;
            end
            ST_F3: begin
                mix_high_next = mul_out;
                state_next    = ST_F4;
            end
            ST_F4: begin
                // Hold until the output register can take the hash.
                if (out_free) begin
                    out_data_next   = {mix_high_reg, mul_out};
                    out_valid_next  = 1'b1;
                    mix_high_next   = start_high;
                    mix_low_next    = seed_next[63:32];
                    bytes_left_next = start_len;
                    parity_next     = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // A write to the seed or key-length register reloads the key state.
        if (cfg_hit) begin
            mix_high_next   = start_high;
            mix_low_next    = seed_next[63:32];
            bytes_left_next = start_len;
            parity_next     = 1'b0;
            state_next      = ST_IDLE;
        end
    end

    // Control and key state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            seed_reg       <= '0;
            key_len_reg    <= KEY_LEN_RESET;
            mix_high_reg   <= 32'(CNT_W'(16 > MAX_KEY_BYTES ? MAX_KEY_BYTES : 16));
            mix_low_reg    <= '0;
            bytes_left_reg <= CNT_W'(16 > MAX_KEY_BYTES ? MAX_KEY_BYTES : 16);
            parity_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            seed_reg       <= seed_next;
            key_len_reg    <= key_len_next;
            mix_high_reg   <= mix_high_next;
            mix_low_reg    <= mix_low_next;
            bytes_left_reg <= bytes_left_next;
            parity_reg     <= parity_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        word_reg     <= word_next;
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

/* dv/murmur64b_key_hash_core_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// murmur64b_key_hash_core_test
// Self-checking bench for the streaming 64-bit MurmurHash2 (64B) key hash.
// A queue-fed driver streams key words into the core. A clocked monitor
// compares every hash against a cycle-free model of the key state kept in
// the bench. Phases change the seed and key length, including the clamped
// lengths, keys dropped by a register write, and ignored register indexes.
// Both sides idle at several rates, and one long output hold-off backs the
// core up.
// ----------------------------------------------------------------------------
module murmur64b_key_hash_core_test;
    import mur64b_pkg::*;

    localparam int unsigned KEY_BYTES_MAX = 64;
    localparam int unsigned RANDOM_WORDS  = 1000;
    localparam int unsigned SETTLE_CYCLES = 20;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam longint unsigned CYCLE_LIMIT = 400000;

    // Register indexes that the core decodes as no register.
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_B = 2'd3;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [SEED_W-1:0]     cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata   = '0;   // [31:0] data_word
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [63:0]           m_tdata;          // [63:0] hash_value

    murmur64b_key_hash_core #(
        .MAX_KEY_BYTES(KEY_BYTES_MAX)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 8 ns clock.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Shared bench state.
    logic [31:0] pending_words[$];
    logic [63:0] expected_hashes[$];
    int unsigned words_queued   = 0;
    int unsigned words_taken    = 0;
    int unsigned hashes_checked = 0;
    int unsigned mismatches     = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_requests  = 0;
    longint unsigned cycle_count = 0;

    // Key state of the bench's own hash model.
    logic [63:0] seed_q;
    logic [6:0]  length_q;
    logic [31:0] acc_hi;
    logic [31:0] acc_lo;
    logic [6:0]  bytes_owed;
    logic        odd_word;

    function automatic logic [31:0] times_m(input logic [31:0] x);
        return x * MUR_M;
    endfunction

    // A length of zero hashes one byte; long lengths clamp to the maximum.
    function automatic logic [6:0] clamp_length(input logic [6:0] n);
        if (n == 7'd0) begin
            return 7'd1;
        end
        if (n > KEY_BYTES_MAX) begin
            return 7'(KEY_BYTES_MAX);
        end
        return n;
    endfunction

    function automatic int unsigned words_per_key(input logic [6:0] n);
        return (int'(clamp_length(n)) + 3) / 4;
    endfunction

    task automatic restart_key();
        bytes_owed = clamp_length(length_q);
        acc_hi     = seed_q[31:0] ^ {25'd0, bytes_owed};
        acc_lo     = seed_q[63:32];
        odd_word   = 1'b0;
    endtask

    // A register write reloads the key state; spare indexes change nothing.
    task automatic apply_register(input logic [CFG_ADDR_W-1:0] idx,
                                  input logic [63:0] val);
        case (idx)
            REG_HASH_SEED: begin
                seed_q = val;
                restart_key();
            end
            REG_KEY_LENGTH: begin
                length_q = val[6:0];
                restart_key();
            end
            default: begin
            end
        endcase
    endtask

    // Mixes one key word in; reports the hash when the key is complete.
    task automatic absorb_key_word(input logic [31:0] w, output bit done,
                                   output logic [63:0] hash);
        logic [31:0] k;
        logic [31:0] mask;
        logic [31:0] h1;
        logic [31:0] h2;
        done = 1'b0;
        hash = '0;
        if (bytes_owed >= 7'd4) begin
            k = times_m(w);
            k = k ^ (k >> MUR_R);
            k = times_m(k);
            if (!odd_word) begin
                acc_hi = times_m(acc_hi) ^ k;
            end else begin
                acc_lo = times_m(acc_lo) ^ k;
            end
            odd_word   = ~odd_word;
            bytes_owed = bytes_owed - 7'd4;
        end else begin
            // Tail word: only the remaining one to three bytes count.
            mask       = (32'd1 << (8 * bytes_owed[1:0])) - 32'd1;
            acc_lo     = times_m(acc_lo ^ (w & mask));
            bytes_owed = 7'd0;
        end
        if (bytes_owed == 7'd0) begin
            h1 = acc_hi;
            h2 = acc_lo;
            h1 = times_m(h1 ^ (h2 >> FIN_SH_A));
            h2 = times_m(h2 ^ (h1 >> FIN_SH_B));
            h1 = times_m(h1 ^ (h2 >> FIN_SH_C));
            h2 = times_m(h2 ^ (h1 >> FIN_SH_D));
            hash = {h1, h2};
            done = 1'b1;
            restart_key();
        end
    endtask

    // Input driver: predicts on each accepted word, then offers the next.
    always @(posedge aclk) begin : drive_words
        bit          done;
        logic [63:0] hash;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                absorb_key_word(s_tdata, done, hash);
                if (done) begin
                    expected_hashes.push_back(hash);
                end
                words_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_words.size() > 0 &&
                    $urandom_range(99, 0) >= send_idle_pct) begin
                    s_tdata  <= pending_words.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: checks each hash transfer and paces m_tready.
    always @(posedge aclk) begin : check_hashes
        int unsigned hold_left;
        int unsigned holds_done;
        logic [63:0] want;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            hold_left  = 0;
            holds_done = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_hashes.size() == 0) begin
                    $error("hash_value: unexpected transfer %016h", m_tdata);
                    mismatches++;
                end else begin
                    want = expected_hashes.pop_front();
                    if (m_tdata !== want) begin
                        $error("hash_value mismatch: expected %016h, got %016h",
                               want, m_tdata);
                        mismatches++;
                    end
                    hashes_checked++;
                end
            end
            if (holds_done != hold_requests) begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
            end
        end
    end

    // Cycle limit.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic queue_word(input logic [31:0] w);
        pending_words.push_back(w);
        words_queued++;
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(9, 0))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic write_register(input logic [CFG_ADDR_W-1:0] idx,
                                  input logic [63:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        apply_register(idx, val);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Waits until every queued word is taken and every hash has come back,
    // then lets a word still in the multiplier finish.
    task automatic wait_idle();
        while (words_taken != words_queued || expected_hashes.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [63:0] pick_seed();
        case ($urandom_range(3, 0))
            0: return 64'd0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial begin : stimulus
        int unsigned phase;
        int unsigned phase_words;
        int unsigned wpk;
        int unsigned partial;
        logic [63:0] seed_val;
        logic [63:0] len_val;
        seed_q   = '0;
        length_q = KEY_LEN_RESET;
        restart_key();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Directed: reset configuration, sixteen-byte key of extreme words.
        queue_word(32'h0000_0000);
        queue_word(32'hffff_ffff);
        queue_word(32'h8000_0000);
        queue_word(32'h0000_0001);
        wait_idle();

        // Length zero acts as one byte, then short tail-only keys.
        write_register(REG_KEY_LENGTH, 64'd0);
        queue_word(32'hffff_ffff);
        wait_idle();
        write_register(REG_KEY_LENGTH, 64'd2);
        queue_word(32'hffff_ffff);
        wait_idle();
        write_register(REG_KEY_LENGTH, 64'd3);
        queue_word(32'hffff_ffff);
        wait_idle();

        // Full word followed by a one-byte tail.
        write_register(REG_KEY_LENGTH, 64'd5);
        queue_word(32'h1234_5678);
        queue_word(32'hffff_ffff);
        wait_idle();

        // A seed write in the middle of a key drops that key.
        write_register(REG_KEY_LENGTH, 64'd8);
        queue_word(32'hdead_beef);
        wait_idle();
        write_register(REG_HASH_SEED, 64'hffff_ffff_ffff_ffff);
        queue_word(32'h0bad_f00d);
        queue_word(32'h7fff_ffff);
        wait_idle();

        // Writes to spare indexes leave a key in progress alone.
        queue_word(32'h0000_00ff);
        wait_idle();
        write_register(REG_SPARE_A, '1);
        write_register(REG_SPARE_B, 64'd4);
        queue_word(32'hff00_0000);
        wait_idle();

        // Long output hold-off with the sender streaming one-word keys.
        write_register(REG_HASH_SEED, {$urandom, $urandom});
        write_register(REG_KEY_LENGTH, 64'd4);
        hold_requests++;
        repeat (40) queue_word(pick_word());
        wait_idle();

        // Random phases over seeds, lengths and idling patterns.
        phase = 0;
        while (words_queued < RANDOM_WORDS + 60) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            case (phase % 8)
                0: begin seed_val = 64'd0; len_val = 64'd1; end
                1: begin seed_val = '1; len_val = 64'd64; end
                2: begin seed_val = pick_seed(); len_val = 64'd127; end
                3: begin seed_val = pick_seed(); len_val = 64'd65; end
                4: begin seed_val = pick_seed(); len_val = 64'd0; end
                5: begin
                    seed_val = pick_seed();
                    len_val  = 64'($urandom_range(1, 64));
                end
                default: begin
                    seed_val = pick_seed();
                    len_val  = 64'($urandom_range(1, 20));
                end
            endcase
            // Bits above the length field are don't-care to the core.
            if ($urandom_range(1, 0) == 1) begin
                len_val[63:7] = 57'({$urandom, $urandom});
            end
            write_register(REG_HASH_SEED, seed_val);
            write_register(REG_KEY_LENGTH, len_val);

            wpk = words_per_key(len_val[6:0]);
            phase_words = 0;
            while (phase_words < 60) begin
                repeat (wpk) queue_word(pick_word());
                phase_words += wpk;
            end
            // Now and then leave a key unfinished for the next write to drop.
            if (phase % 5 == 4 && wpk > 1) begin
                partial = $urandom_range(wpk - 1, 1);
                repeat (partial) queue_word(pick_word());
            end
            wait_idle();
            phase++;
        end

        $display("Covered %0d key words and %0d hashes over %0d random phases,",
                 words_taken, hashes_checked, phase);
        $display("with clamped lengths, dropped keys, spare writes and a long hold-off.");
        if (mismatches == 0 && expected_hashes.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/mur64b_pkg.sv
rtl/core/murmur64b_key_hash_core.sv
dv/murmur64b_key_hash_core_test.sv
